FILE: sv/msr_pkg.sv
// Package for the modular square root block: widths, status codes, constants.
// No dependencies.
`default_nettype none
package msr_pkg;
    localparam int W = 32;
    localparam logic [W-1:0] MOD_RESET = 32'd1000000007;
    localparam logic [W-1:0] NONRES_LIMIT = 32'd4096;
    localparam logic [1:0]   ADDR_MODULUS = 2'd0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NONRES   = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTPRIME = 2'd3
    } status_t;

    typedef struct packed {
        logic         start;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] m;
    } mul_req_t;
endpackage
`default_nettype wire

FILE: sv/msr_mulmod.sv
// Bit-serial modular multiplier: r = a*b mod m, one bit of b per cycle.
// Depends on msr_pkg.
`default_nettype none
module msr_mulmod
    import msr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire mul_req_t     req,
    output logic              done,
    output logic [W-1:0]      result
);
    logic [W-1:0] a_reg, b_reg, m_reg, r_reg;
    logic [5:0]   cnt_reg;
    logic         busy_reg;
    logic [W:0]   dbl, dsub, adds, asub;
    logic [W-1:0] r1, r2;

    always_comb
    begin
        dbl  = {r_reg, 1'b0};
        dsub = dbl - {1'b0, m_reg};
        r1   = (dbl >= {1'b0, m_reg}) ? dsub[W-1:0] : dbl[W-1:0];
        adds = {1'b0, r1} + {1'b0, a_reg};
        asub = adds - {1'b0, m_reg};
        if (b_reg[W-1])
            r2 = (adds >= {1'b0, m_reg}) ? asub[W-1:0] : adds[W-1:0];
        else
            r2 = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(W);
                a_reg    <= req.a;
                b_reg    <= req.b;
                m_reg    <= req.m;
                r_reg    <= '0;
            end
            else if (busy_reg)
            begin
                r_reg   <= r2;
                b_reg   <= {b_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign result = r_reg;
endmodule
`default_nettype wire

FILE: sv/msr_seq.sv
// Sequencer for Tonelli-Shanks: drives the shared modular multiplier.
// Depends on msr_pkg and msr_mulmod.
`default_nettype none
module msr_seq
    import msr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         go,
    input  wire logic [W-1:0] x_in,
    input  wire logic [W-1:0] p_in,
    output logic              busy,
    output logic              fin,
    output logic [W-1:0]      root_out,
    output status_t           st_out
);
    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_POW_INIT, S_POW_MUL, S_POW_MW, S_POW_SQ, S_POW_SW,
        S_EULER_DONE, S_FACTOR, S_Z_CHECK, S_C_DONE, S_T_DONE, S_R_DONE,
        S_LOOP, S_SQ_W, S_SQ_CHK, S_B_SQ, S_B_W, S_C_W, S_T_W, S_RB_W,
        S_FINAL_W, S_FINAL
    } state_t;

    typedef enum logic [2:0] {
        P_EULER, P_R34, P_ZTEST, P_C, P_T, P_R
    } pow_t;

    state_t       state_reg;
    pow_t         pw_reg, ret_reg;
    logic [W-1:0] p_reg, x_reg, half_reg, q_reg, z_reg, zlim_reg;
    logic [W-1:0] c_reg, t_reg, r_reg, b_reg, sq_reg;
    logic [W-1:0] pb_reg, pe_reg, pr_reg;
    logic [5:0]   s_reg, m_reg, i_reg, k_reg;
    mul_req_t     req;
    logic         mdone;
    logic [W-1:0] mres;
    logic [W-1:0] pmr;

    msr_mulmod u_mul (.clk(clk), .rst_n(rst_n), .req(req), .done(mdone), .result(mres));

    assign pmr = p_reg - r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin       <= 1'b0;
            req       <= '0;
            st_out    <= ST_OK;
            root_out  <= '0;
            pw_reg    <= P_EULER;
            ret_reg   <= P_EULER;
        end
        else
        begin
            fin       <= 1'b0;
            req.start <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        p_reg     <= p_in;
                        x_reg     <= x_in;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    half_reg <= {1'b0, p_reg[W-1:1]};
                    if (p_reg < 3 || !p_reg[0])
                    begin
                        st_out <= ST_NOTPRIME; root_out <= '0; fin <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (x_reg >= p_reg)
                    begin
                        st_out <= ST_RANGE; root_out <= '0; fin <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (x_reg == '0)
                    begin
                        st_out <= ST_OK; root_out <= '0; fin <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        pb_reg <= x_reg; pe_reg <= {1'b0, p_reg[W-1:1]};
                        pr_reg <= W'(1); ret_reg <= P_EULER;
                        state_reg <= S_POW_INIT;
                    end
                end
                // exponent loop: multiply on set bit, square base, shift
                S_POW_INIT:
                begin
                    pw_reg <= ret_reg;
                    if (pe_reg == '0)
                        state_reg <= S_EULER_DONE;
                    else if (pe_reg[0])
                    begin
                        req <= '{start: 1'b1, a: pr_reg, b: pb_reg, m: p_reg};
                        state_reg <= S_POW_MW;
                    end
                    else
                        state_reg <= S_POW_SQ;
                end
                S_POW_MW:
                begin
                    if (mdone)
                    begin
                        pr_reg <= mres;
                        state_reg <= S_POW_SQ;
                    end
                end
                S_POW_SQ:
                begin
                    req <= '{start: 1'b1, a: pb_reg, b: pb_reg, m: p_reg};
                    state_reg <= S_POW_SW;
                end
                S_POW_SW:
                begin
                    if (mdone)
                    begin
                        pb_reg <= mres;
                        pe_reg <= {1'b0, pe_reg[W-1:1]};
                        state_reg <= S_POW_INIT;
                    end
                end
                S_POW_MUL: state_reg <= S_POW_INIT;
                S_EULER_DONE:
                begin
                    case (pw_reg)
                        P_EULER:
                        begin
                            if (pr_reg != W'(1))
                            begin
                                st_out <= ST_NONRES; root_out <= '0; fin <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else if (p_reg[1:0] == 2'b11)
                            begin
                                pb_reg <= x_reg;
                                pe_reg <= {2'b00, p_reg[W-1:2]} + W'(1);
                                pr_reg <= W'(1); ret_reg <= P_R34;
                                state_reg <= S_POW_INIT;
                            end
                            else
                            begin
                                q_reg <= p_reg - W'(1); s_reg <= '0;
                                state_reg <= S_FACTOR;
                            end
                        end
                        P_R34:
                        begin
                            r_reg <= pr_reg;
                            state_reg <= S_FINAL;
                        end
                        P_ZTEST:
                        begin
                            if (pr_reg != W'(1))
                            begin
                                pb_reg <= z_reg; pe_reg <= q_reg; pr_reg <= W'(1);
                                ret_reg <= P_C; state_reg <= S_POW_INIT;
                            end
                            else
                            begin
                                z_reg <= z_reg + W'(1);
                                state_reg <= S_Z_CHECK;
                            end
                        end
                        P_C:
                        begin
                            c_reg <= pr_reg; m_reg <= s_reg;
                            pb_reg <= x_reg; pe_reg <= q_reg; pr_reg <= W'(1);
                            ret_reg <= P_T; state_reg <= S_POW_INIT;
                        end
                        P_T:
                        begin
                            t_reg <= pr_reg;
                            pb_reg <= x_reg;
                            pe_reg <= {1'b0, q_reg[W-1:1]} + W'(1);
                            pr_reg <= W'(1); ret_reg <= P_R; state_reg <= S_POW_INIT;
                        end
                        default:
                        begin
                            r_reg <= pr_reg;
                            state_reg <= S_LOOP;
                        end
                    endcase
                end
                S_FACTOR:
                begin
                    if (!q_reg[0])
                    begin
                        q_reg <= {1'b0, q_reg[W-1:1]};
                        s_reg <= s_reg + 6'd1;
                    end
                    else
                    begin
                        z_reg <= W'(2);
                        zlim_reg <= (p_reg - W'(1) < NONRES_LIMIT) ? p_reg - W'(1)
                                                                  : NONRES_LIMIT;
                        state_reg <= S_Z_CHECK;
                    end
                end
                S_Z_CHECK:
                begin
                    if (z_reg > zlim_reg)
                    begin
                        st_out <= ST_NOTPRIME; root_out <= '0; fin <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        pb_reg <= z_reg; pe_reg <= half_reg; pr_reg <= W'(1);
                        ret_reg <= P_ZTEST; state_reg <= S_POW_INIT;
                    end
                end
                S_LOOP:
                begin
                    if (t_reg == '0 || t_reg == W'(1))
                        state_reg <= S_FINAL;
                    else
                    begin
                        i_reg <= 6'd1;
                        req <= '{start: 1'b1, a: t_reg, b: t_reg, m: p_reg};
                        state_reg <= S_SQ_W;
                    end
                end
                S_SQ_W:
                begin
                    if (mdone)
                    begin
                        sq_reg <= mres;
                        state_reg <= S_SQ_CHK;
                    end
                end
                S_SQ_CHK:
                begin
                    if (sq_reg != W'(1) && i_reg < m_reg)
                    begin
                        i_reg <= i_reg + 6'd1;
                        req <= '{start: 1'b1, a: sq_reg, b: sq_reg, m: p_reg};
                        state_reg <= S_SQ_W;
                    end
                    else if (i_reg >= m_reg)
                    begin
                        st_out <= ST_NOTPRIME; root_out <= '0; fin <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        b_reg <= c_reg; k_reg <= '0;
                        state_reg <= S_B_SQ;
                    end
                end
                S_B_SQ:
                begin
                    if (k_reg + 6'd1 < m_reg - i_reg)
                    begin
                        req <= '{start: 1'b1, a: b_reg, b: b_reg, m: p_reg};
                        state_reg <= S_B_W;
                    end
                    else
                    begin
                        m_reg <= i_reg;
                        req <= '{start: 1'b1, a: b_reg, b: b_reg, m: p_reg};
                        state_reg <= S_C_W;
                    end
                end
                S_B_W:
                begin
                    if (mdone)
                    begin
                        b_reg <= mres; k_reg <= k_reg + 6'd1;
                        state_reg <= S_B_SQ;
                    end
                end
                S_C_W:
                begin
                    if (mdone)
                    begin
                        c_reg <= mres;
                        req <= '{start: 1'b1, a: t_reg, b: mres, m: p_reg};
                        state_reg <= S_T_W;
                    end
                end
                S_T_W:
                begin
                    if (mdone)
                    begin
                        t_reg <= mres;
                        req <= '{start: 1'b1, a: r_reg, b: b_reg, m: p_reg};
                        state_reg <= S_RB_W;
                    end
                end
                S_RB_W:
                begin
                    if (mdone)
                    begin
                        r_reg <= mres;
                        state_reg <= S_LOOP;
                    end
                end
                S_FINAL:
                begin
                    req <= '{start: 1'b1, a: r_reg, b: r_reg, m: p_reg};
                    state_reg <= S_FINAL_W;
                end
                S_FINAL_W:
                begin
                    if (mdone)
                    begin
                        fin <= 1'b1;
                        state_reg <= S_IDLE;
                        if (mres != x_reg)
                        begin
                            st_out <= ST_NOTPRIME; root_out <= '0;
                        end
                        else
                        begin
                            st_out <= ST_OK;
                            root_out <= (pmr < r_reg) ? pmr : r_reg;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire

FILE: sv/modular_square_root_top.sv
// Top level of the modular square root block: APB register and command port.
// Depends on msr_pkg and msr_seq.
`default_nettype none
// Returns the smaller square root of value modulo the odd prime in the modulus
// register (byte address 0). Pulse start while busy is low; one result appears
// on root/status with done high for exactly one cycle and must be taken then.
// Every modular product runs through one bit-serial multiplier, which takes
// a request and then works through the second operand bit by bit. An
// exponentiation squares the base once per exponent bit and multiplies once
// more per set bit. Tonelli-Shanks adds one exponentiation per non-residue
// candidate, three more, and the reduction loop. The special cases raise done
// straight from the check state after start is taken.
module modular_square_root_top
    import msr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    input  wire logic [31:0] value,
    output logic             busy,
    output logic             done,
    output logic [31:0]      root,
    output logic [1:0]       status
);
    logic [W-1:0] modulus_reg;
    status_t      st;
    logic         sbusy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MOD_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_MODULUS)
            modulus_reg <= pwdata;
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODULUS) ? modulus_reg : '0;

    msr_seq u_seq (
        .clk(clk), .rst_n(rst_n), .go(start && !sbusy), .x_in(value),
        .p_in(modulus_reg), .busy(sbusy), .fin(done), .root_out(root), .st_out(st)
    );

    assign busy   = sbusy;
    assign status = st;
endmodule
`default_nettype wire
